/* rtl/core/csvrs_pkg.sv */
// Shared types, constants and the quote scanner for the CSV record splitter.
// No dependencies; every other file of the block refers to this package by scoped names.
package csvrs_pkg;

    // Character codes the splitter looks at.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Default depth of the queue between the front and the back.
    localparam int FIFO_DEPTH = 4;

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_REC_END   = 2'd1,
        KIND_DISCARD   = 2'd2,
        KIND_INPUT_END = 2'd3
    } t_kind;

    // Quote-tracking state of the record scanner.
    typedef struct packed {
        logic in_quote;
        logic quote_pending;
        logic field_started;
        logic literal_cr_seen;
        logic skip_next;
        logic tracking_stopped;
    } t_scan;

    // One queue entry: the results caused by one input transfer.
    typedef struct packed {
        logic        two;
        t_kind       kind0;
        logic [7:0]  byte0;
        t_kind       kind1;
        logic [7:0]  byte1;
        logic [31:0] count;
    } t_entry;

    // Shift-JIS lead byte ranges.
    function automatic logic is_lead(input logic [7:0] b);
        return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
    endfunction

    // A record is complete when it is not inside an open quoted field.
    function automatic logic is_complete(input t_scan s);
        return s.tracking_stopped || s.quote_pending || !s.in_quote;
    endfunction

    // Advance the scanner by one payload byte.
    function automatic t_scan scan_byte(input t_scan s, input logic [7:0] b,
                                        input logic dbcs);
        t_scan r;
        logic  done;
        r    = s;
        done = 1'b0;
        if (r.tracking_stopped) begin
            done = 1'b1;
        end else if (r.skip_next) begin
            r.skip_next = 1'b0;
            done        = 1'b1;
        end
        // A quote inside quotes is either doubled (literal) or a close.
        if (!done && r.quote_pending) begin
            r.quote_pending = 1'b0;
            if (b == CH_QUOTE) begin
                r.field_started = 1'b1;
                done            = 1'b1;
            end else begin
                r.in_quote = 1'b0;
            end
        end
        // An embedded CR followed by LF outside quotes stops tracking.
        if (!done && r.literal_cr_seen) begin
            r.literal_cr_seen = 1'b0;
            if (b == CH_LF) begin
                if (!r.in_quote) begin
                    r.tracking_stopped = 1'b1;
                end else begin
                    r.field_started = 1'b1;
                end
                done = 1'b1;
            end else begin
                r.field_started = 1'b1;
            end
        end
        if (!done && dbcs && is_lead(b)) begin
            r.skip_next     = 1'b1;
            r.field_started = 1'b1;
            done            = 1'b1;
        end
        if (!done) begin
            if (b == CH_COMMA) begin
                r.field_started = r.in_quote;
            end else if (b == CH_QUOTE) begin
                if (r.in_quote) begin
                    r.quote_pending = 1'b1;
                end else if (!r.field_started) begin
                    r.in_quote = 1'b1;
                end
            end else if (b == CH_CR) begin
                r.literal_cr_seen = 1'b1;
            end else begin
                r.field_started = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/csv_record_splitter_core.sv */
// CSV record splitter: one input byte or end-of-input command per cycle in, one result
// per cycle out. Each transfer causes zero, one or two results, so the input side
// takes one item per cycle while the output keeps up; the output side sets the
// sustained rate at one result per cycle while not stalled. The front classifies each
// transfer and writes its results into the result queue, and the back loads the output
// register from the queue head when the output is not stalled. The queue (FIFO_DEPTH
// entries) lets input and output stall independently.
module csv_record_splitter_core #(
    parameter int FIFO_DEPTH = csvrs_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_dbcs_enable_we,
    input  logic        i_dbcs_enable_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_record_count,
    output logic        o_last
);

    logic              push, pop, full, empty;
    csvrs_pkg::t_entry push_entry, head;

    // Front: accept and classify input transfers.
    csvrs_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_dbcs_enable_we   (i_dbcs_enable_we),
        .i_dbcs_enable_data (i_dbcs_enable_data),
        .i_valid            (i_valid),
        .i_cmd              (i_cmd),
        .i_data_byte        (i_data_byte),
        .i_full             (full),
        .o_stall            (o_stall),
        .o_push             (push),
        .o_entry            (push_entry)
    );

    // Result queue.
    csvrs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // Back: deliver results one transfer at a time.
    csvrs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_record_count (o_record_count),
        .o_last         (o_last)
    );

endmodule

/* rtl/core/csvrs_front.sv */
// Front of the CSV record splitter: accepts bytes, tracks quoting and line state,
// counts records and queues the results of each transfer. Depends on csvrs_pkg.
module csvrs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_dbcs_enable_we,
    input  logic                i_dbcs_enable_data,
    input  logic                i_valid,
    input  logic                i_cmd,
    input  logic [7:0]          i_data_byte,
    input  logic                i_full,
    output logic                o_stall,
    output logic                o_push,
    output csvrs_pkg::t_entry   o_entry
);

    logic               r_dbcs;
    csvrs_pkg::t_scan   r_scan, n_scan;
    logic               r_cr_pending, n_cr_pending;
    logic               r_rec_nonempty, n_rec_nonempty;
    logic               r_line_nonempty, n_line_nonempty;
    logic [31:0]        r_count, n_count;
    logic               accept;
    logic               push;
    csvrs_pkg::t_entry  entry;
    csvrs_pkg::t_scan   scan_cr;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // Classify one transfer and work out the next state and the results.
    always_comb begin
        n_scan          = r_scan;
        n_cr_pending    = r_cr_pending;
        n_rec_nonempty  = r_rec_nonempty;
        n_line_nonempty = r_line_nonempty;
        n_count         = r_count;
        push            = 1'b0;
        entry.two       = 1'b0;
        entry.kind0     = csvrs_pkg::KIND_PAYLOAD;
        entry.byte0     = 8'h00;
        entry.kind1     = csvrs_pkg::KIND_PAYLOAD;
        entry.byte1     = 8'h00;
        scan_cr         = csvrs_pkg::scan_byte(r_scan, csvrs_pkg::CH_CR, r_dbcs);
        if (accept) begin
            if (i_cmd == csvrs_pkg::CMD_END) begin
                // End of input: close or discard an open record, then mark the end.
                push         = 1'b1;
                n_cr_pending = 1'b0;
                if (r_rec_nonempty) begin
                    entry.two   = 1'b1;
                    entry.kind1 = csvrs_pkg::KIND_INPUT_END;
                    if (csvrs_pkg::is_complete(r_scan)) begin
                        n_count     = r_count + 32'd1;
                        entry.kind0 = csvrs_pkg::KIND_REC_END;
                    end else begin
                        entry.kind0 = csvrs_pkg::KIND_DISCARD;
                    end
                end else begin
                    entry.kind0 = csvrs_pkg::KIND_INPUT_END;
                end
                n_scan          = '0;
                n_rec_nonempty  = 1'b0;
                n_line_nonempty = 1'b0;
            end else if (r_cr_pending) begin
                n_cr_pending = 1'b0;
                if (i_data_byte == csvrs_pkg::CH_LF) begin
                    // Physical line end.
                    if (csvrs_pkg::is_complete(r_scan)) begin
                        if (r_rec_nonempty) begin
                            n_count = r_count + 32'd1;
                        end
                        push            = 1'b1;
                        entry.kind0     = csvrs_pkg::KIND_REC_END;
                        n_scan          = '0;
                        n_rec_nonempty  = 1'b0;
                        n_line_nonempty = 1'b0;
                    end else if (!r_line_nonempty) begin
                        push            = 1'b1;
                        entry.kind0     = csvrs_pkg::KIND_DISCARD;
                        n_scan          = '0;
                        n_rec_nonempty  = 1'b0;
                        n_line_nonempty = 1'b0;
                    end else begin
                        n_line_nonempty = 1'b0;
                    end
                end else begin
                    // A lone CR goes out together with the byte after it.
                    push            = 1'b1;
                    entry.two       = 1'b1;
                    entry.kind0     = csvrs_pkg::KIND_PAYLOAD;
                    entry.byte0     = csvrs_pkg::CH_CR;
                    entry.kind1     = csvrs_pkg::KIND_PAYLOAD;
                    entry.byte1     = i_data_byte;
                    n_scan          = csvrs_pkg::scan_byte(scan_cr, i_data_byte, r_dbcs);
                    n_rec_nonempty  = 1'b1;
                    n_line_nonempty = 1'b1;
                end
            end else if (i_data_byte == csvrs_pkg::CH_CR) begin
                n_cr_pending = 1'b1;
            end else begin
                push            = 1'b1;
                entry.kind0     = csvrs_pkg::KIND_PAYLOAD;
                entry.byte0     = i_data_byte;
                n_scan          = csvrs_pkg::scan_byte(r_scan, i_data_byte, r_dbcs);
                n_rec_nonempty  = 1'b1;
                n_line_nonempty = 1'b1;
            end
        end
        entry.count = n_count;
    end

    assign o_push  = push;
    assign o_entry = entry;

    // State registers and the configuration bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbcs          <= 1'b1;
            r_scan          <= '0;
            r_cr_pending    <= 1'b0;
            r_rec_nonempty  <= 1'b0;
            r_line_nonempty <= 1'b0;
            r_count         <= 32'd0;
        end else begin
            if (i_dbcs_enable_we) begin
                r_dbcs <= i_dbcs_enable_data;
            end
            r_scan          <= n_scan;
            r_cr_pending    <= n_cr_pending;
            r_rec_nonempty  <= n_rec_nonempty;
            r_line_nonempty <= n_line_nonempty;
            r_count         <= n_count;
        end
    end

endmodule

/* rtl/core/csvrs_fifo.sv */
// Short queue of result entries between the front and the back of the splitter.
// Depends on csvrs_pkg for the entry type.
module csvrs_fifo #(
    parameter int DEPTH = csvrs_pkg::FIFO_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  csvrs_pkg::t_entry   i_entry,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output csvrs_pkg::t_entry   o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    csvrs_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/core/csvrs_back.sv */
// Back of the CSV record splitter: unpacks queued entries into single results
// and holds them in the output register. Depends on csvrs_pkg.
module csvrs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  csvrs_pkg::t_entry   i_head,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_out_byte,
    output logic [31:0]         o_record_count,
    output logic                o_last
);

    logic        r_valid;
    logic        r_second, n_second;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic [31:0] r_count;
    logic        r_last, n_last;
    logic        load;
    logic        pop;

    assign load = !r_valid || !i_stall;

    // Pick the next result from the head entry.
    always_comb begin
        n_second = r_second;
        n_kind   = i_head.kind0;
        n_byte   = i_head.byte0;
        n_last   = 1'b1;
        pop      = 1'b0;
        if (load && !i_empty) begin
            if (i_head.two && !r_second) begin
                n_last   = 1'b0;
                n_second = 1'b1;
            end else begin
                if (i_head.two) begin
                    n_kind = i_head.kind1;
                    n_byte = i_head.byte1;
                end
                n_second = 1'b0;
                pop      = 1'b1;
            end
        end
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
            if (load) begin
                r_valid <= !i_empty;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_kind  <= n_kind;
            r_byte  <= n_byte;
            r_count <= i_head.count;
            r_last  <= n_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_out_byte     = r_byte;
    assign o_record_count = r_count;
    assign o_last         = r_last;

endmodule
